@@ hw/rtl/frrs_pkg.sv @@
// ----------------------------------------------------------------------------
// frrs_pkg
// Shared types and codes of the flow round-robin scheduler.
// ----------------------------------------------------------------------------
package frrs_pkg;

   localparam int CMD_WIDTH    = 2;
   localparam int STATUS_WIDTH = 3;
   localparam int QIDX_WIDTH   = 3;
   localparam int LEN_WIDTH    = 16;
   localparam int TAGP_WIDTH   = 16;
   localparam int ADDR_WIDTH   = 32;
   localparam int SLOT_WIDTH   = 3;
   localparam int FCNT_WIDTH   = 3;
   localparam int MAXP_WIDTH   = 10;
   localparam int MAXB_WIDTH   = 24;
   localparam int CSR_AW       = 4;
   localparam int CSR_DW       = 32;

   localparam logic [CMD_WIDTH-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_PROGRAM = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_ENQUEUED   = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DROPPED    = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DEQUEUED   = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_ALL_EMPTY  = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_PROGRAMMED = 3'd4;

   localparam logic [1:0] REG_QUEUE_MODE  = 2'd0;
   localparam logic [1:0] REG_FLOW_COUNT  = 2'd1;
   localparam logic [1:0] REG_MAX_PACKETS = 2'd2;
   localparam logic [1:0] REG_MAX_BYTES   = 2'd3;

   localparam logic                  RST_QUEUE_MODE  = 1'b1;
   localparam logic [FCNT_WIDTH-1:0] RST_FLOW_COUNT  = 3'd3;
   localparam logic [MAXP_WIDTH-1:0] RST_MAX_PACKETS = 10'd100;
   localparam logic [MAXB_WIDTH-1:0] RST_MAX_BYTES   = 24'd6553500;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_ENQ,
      FSM_DEQ_READ,
      FSM_DEQ_DONE,
      FSM_RESP
   } fsm_type;

endpackage

@@ hw/rtl/frrs_ram.sv @@
// ----------------------------------------------------------------------------
// frrs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module frrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 448
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/frrs_div.sv @@
// ----------------------------------------------------------------------------
// frrs_div
// Restoring divider of a wide value by a narrow divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module frrs_div #(
   parameter int W  = 24,
   parameter int DW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [W-1:0]  num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [W-1:0]  quot
);

   localparam int CNTW = $clog2(W + 1);

   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    quot_ff, quot_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW:0]     shifted;

   always_comb begin
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, quot_ff[W-1]};
      if (start) begin
         cnt_in  = CNTW'(W);
         quot_in = num;
         rem_in  = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (shifted >= {1'b0, den}) begin
            rem_in  = DW'(shifted - {1'b0, den});
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DW-1:0];
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy = (cnt_ff != '0);
   assign quot = quot_ff;

endmodule

@@ hw/rtl/flow_round_robin_scheduler.sv @@
// ----------------------------------------------------------------------------
// flow_round_robin_scheduler
// Per-flow packet queues with a flow table and round-robin dequeue.
// ----------------------------------------------------------------------------
// Commands enter on the req_ channel (valid/stall): enqueue, dequeue or
// program a flow table slot. Every enqueue, dequeue and program transaction
// yields one rsp_ transaction; an unknown command yields none.
// Packet descriptors sit in one RAM of (MAX_FLOWS+1)*QUEUE_DEPTH entries;
// head, fill and byte count of each queue are kept in flops.
// From acceptance to rsp_valid every transaction passes the lookup state; an
// enqueue then passes its enqueue state and a dequeue that finds a packet a
// RAM read and a write back, before the response state loads the result.
// One transaction is in the block at a time.
// The per-queue limits (max / flow count) are computed by two bit-serial
// dividers after reset and after every register write; req_stall stays high
// while they run.
// Reset empties all queues and the flow table and loads register defaults.
// A stalled result holds in the output register; the next transaction may be
// accepted meanwhile but waits before its own result is loaded.
// ----------------------------------------------------------------------------
module flow_round_robin_scheduler #(
   parameter int MAX_FLOWS   = 6,
   parameter int QUEUE_DEPTH = 64,
   parameter int TAG_WIDTH   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [frrs_pkg::CMD_WIDTH-1:0]        req_command,
   input  logic [frrs_pkg::ADDR_WIDTH-1:0]       req_src_address,
   input  logic [frrs_pkg::ADDR_WIDTH-1:0]       req_dst_address,
   input  logic [frrs_pkg::LEN_WIDTH-1:0]        req_packet_length,
   input  logic [frrs_pkg::TAGP_WIDTH-1:0]       req_packet_tag,
   input  logic [frrs_pkg::SLOT_WIDTH-1:0]       req_flow_slot,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [frrs_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic [frrs_pkg::QIDX_WIDTH-1:0]       rsp_queue_index,
   output logic [frrs_pkg::TAGP_WIDTH-1:0]       rsp_out_tag,
   output logic [frrs_pkg::LEN_WIDTH-1:0]        rsp_out_length,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [frrs_pkg::CSR_AW-1:0]           paddr,
   input  logic [frrs_pkg::CSR_DW-1:0]           pwdata,
   output logic [frrs_pkg::CSR_DW-1:0]           prdata,
   output logic                                  pready
);

   localparam int NQ   = MAX_FLOWS + 1;
   localparam int IW   = $clog2(NQ);
   localparam int QW   = $clog2(NQ + 1);
   localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int TW   = (TAG_WIDTH < frrs_pkg::TAGP_WIDTH) ? TAG_WIDTH : frrs_pkg::TAGP_WIDTH;
   localparam int EW   = TW + frrs_pkg::LEN_WIDTH;
   localparam int RD   = NQ * QUEUE_DEPTH;
   localparam int AW   = $clog2(RD);
   localparam int BW   = frrs_pkg::MAXB_WIDTH;
   localparam int LW   = frrs_pkg::LEN_WIDTH;

   // configuration registers
   logic                                queue_mode_ff;
   logic [frrs_pkg::FCNT_WIDTH-1:0]     flow_count_ff;
   logic [frrs_pkg::MAXP_WIDTH-1:0]     max_packets_ff;
   logic [BW-1:0]                       max_bytes_ff;
   logic                                cfg_wr;
   logic                                recalc_ff, recalc_in;
   logic                                div_start, div_busy_p, div_busy_b;
   logic [frrs_pkg::MAXP_WIDTH-1:0]     pkt_limit;
   logic [BW-1:0]                       byte_limit;
   logic [IW-1:0]                       fc;

   // flow table and queue state
   logic [frrs_pkg::ADDR_WIDTH-1:0]     flow_src_ff [MAX_FLOWS];
   logic [frrs_pkg::ADDR_WIDTH-1:0]     flow_dst_ff [MAX_FLOWS];
   logic [MAX_FLOWS-1:0]                flow_valid_ff;
   logic [HW-1:0]                       head_ff [NQ];
   logic [CW-1:0]                       fill_ff [NQ];
   logic [BW-1:0]                       bytes_ff [NQ];
   logic [IW-1:0]                       turn_ff, turn_in;

   // latched transaction
   logic [frrs_pkg::CMD_WIDTH-1:0]      cmd_ff;
   logic [frrs_pkg::ADDR_WIDTH-1:0]     src_ff, dst_ff;
   logic [LW-1:0]                       len_ff;
   logic [TW-1:0]                       tag_ff;
   logic [frrs_pkg::SLOT_WIDTH-1:0]     slot_ff;
   logic [IW-1:0]                       q_ff, q_in;

   // pending and output result
   logic [frrs_pkg::STATUS_WIDTH-1:0]   res_status_ff, res_status_in;
   logic [frrs_pkg::QIDX_WIDTH-1:0]     res_q_ff, res_q_in;
   logic [frrs_pkg::TAGP_WIDTH-1:0]     res_tag_ff, res_tag_in;
   logic [LW-1:0]                       res_len_ff, res_len_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [frrs_pkg::STATUS_WIDTH-1:0]   rsp_status_ff;
   logic [frrs_pkg::QIDX_WIDTH-1:0]     rsp_q_ff;
   logic [frrs_pkg::TAGP_WIDTH-1:0]     rsp_tag_ff;
   logic [LW-1:0]                       rsp_len_ff;

   frrs_pkg::fsm_type state_ff, state_in;

   logic                                accept;
   logic                                rsp_free;
   logic                                load_rsp;

   // memory port
   logic                                ram_wr_en, ram_rd_en;
   logic [AW-1:0]                       ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]                       ram_wr_data, ram_rd_data;

   // datapath intermediates
   logic [IW-1:0]                       match_q, scan_q;
   logic                                scan_found;
   logic [QW-1:0]                       n_q, start_q;
   logic [QW:0]                         scan_idx;
   logic [CW-1:0]                       fill_q;
   logic [BW-1:0]                       bytes_q;
   logic [HW-1:0]                       head_q;
   logic [HW:0]                         pos_sum;
   logic [HW-1:0]                       pos;
   logic [BW:0]                         byte_sum;
   logic                                drop;
   logic [LW-1:0]                       plen;
   logic                                head_upd, enq_upd;

   // ---------------------------------------------------------------- config
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_mode_ff  <= frrs_pkg::RST_QUEUE_MODE;
         flow_count_ff  <= frrs_pkg::RST_FLOW_COUNT;
         max_packets_ff <= frrs_pkg::RST_MAX_PACKETS;
         max_bytes_ff   <= frrs_pkg::RST_MAX_BYTES;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            frrs_pkg::REG_QUEUE_MODE:  queue_mode_ff  <= pwdata[0];
            frrs_pkg::REG_FLOW_COUNT:  flow_count_ff  <= pwdata[frrs_pkg::FCNT_WIDTH-1:0];
            frrs_pkg::REG_MAX_PACKETS: max_packets_ff <= pwdata[frrs_pkg::MAXP_WIDTH-1:0];
            frrs_pkg::REG_MAX_BYTES:   max_bytes_ff   <= pwdata[BW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         frrs_pkg::REG_QUEUE_MODE:  prdata = 32'(queue_mode_ff);
         frrs_pkg::REG_FLOW_COUNT:  prdata = 32'(flow_count_ff);
         frrs_pkg::REG_MAX_PACKETS: prdata = 32'(max_packets_ff);
         frrs_pkg::REG_MAX_BYTES:   prdata = 32'(max_bytes_ff);
         default:                   prdata = '0;
      endcase
   end

   // flow count clamped to 1..MAX_FLOWS
   always_comb begin
      if (flow_count_ff == '0) begin
         fc = IW'(1);
      end else if (32'(flow_count_ff) > MAX_FLOWS) begin
         fc = IW'(MAX_FLOWS);
      end else begin
         fc = IW'(flow_count_ff);
      end
   end

   assign div_start = recalc_ff & ~div_busy_p & ~div_busy_b;
   assign recalc_in = cfg_wr ? 1'b1 : (div_start ? 1'b0 : recalc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         recalc_ff <= 1'b1;
      end else begin
         recalc_ff <= recalc_in;
      end
   end

   frrs_div #(.W(frrs_pkg::MAXP_WIDTH), .DW(IW)) u_div_pkt (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (max_packets_ff),
      .den   (fc),
      .busy  (div_busy_p),
      .quot  (pkt_limit)
   );

   frrs_div #(.W(BW), .DW(IW)) u_div_byte (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (max_bytes_ff),
      .den   (fc),
      .busy  (div_busy_b),
      .quot  (byte_limit)
   );

   // ---------------------------------------------------------------- handshake
   assign req_stall = (state_ff != frrs_pkg::FSM_IDLE) | recalc_ff | div_busy_p | div_busy_b;
   assign accept    = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frrs_pkg::FSM_IDLE: begin
            if (accept) state_in = frrs_pkg::FSM_LOOKUP;
         end
         frrs_pkg::FSM_LOOKUP: begin
            priority if (cmd_ff == frrs_pkg::CMD_ENQUEUE) state_in = frrs_pkg::FSM_ENQ;
            else if (cmd_ff == frrs_pkg::CMD_DEQUEUE)
               state_in = scan_found ? frrs_pkg::FSM_DEQ_READ : frrs_pkg::FSM_RESP;
            else if (cmd_ff == frrs_pkg::CMD_PROGRAM) state_in = frrs_pkg::FSM_RESP;
            else state_in = frrs_pkg::FSM_IDLE;
         end
         frrs_pkg::FSM_ENQ:      state_in = frrs_pkg::FSM_RESP;
         frrs_pkg::FSM_DEQ_READ: state_in = frrs_pkg::FSM_DEQ_DONE;
         frrs_pkg::FSM_DEQ_DONE: state_in = frrs_pkg::FSM_RESP;
         frrs_pkg::FSM_RESP: begin
            if (rsp_free) state_in = frrs_pkg::FSM_IDLE;
         end
         default: state_in = frrs_pkg::FSM_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control strobes
   always_comb begin
      ram_rd_en = 1'b0;
      head_upd  = 1'b0;
      enq_upd   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         frrs_pkg::FSM_ENQ:      enq_upd   = ~drop;
         frrs_pkg::FSM_DEQ_READ: ram_rd_en = 1'b1;
         frrs_pkg::FSM_DEQ_DONE: head_upd  = 1'b1;
         frrs_pkg::FSM_RESP:     load_rsp  = rsp_free;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- lookup
   always_comb begin
      match_q = fc;
      for (int i = 0; i < MAX_FLOWS; i++) begin
         if ((IW'(i) < fc) && flow_valid_ff[i] &&
             (flow_src_ff[i] == src_ff) && (flow_dst_ff[i] == dst_ff)) begin
            match_q = IW'(i);
         end
      end
   end

   // round-robin scan over queues 0..fc starting at turn
   always_comb begin
      n_q        = QW'(fc) + 1'b1;
      start_q    = (QW'(turn_ff) < n_q) ? QW'(turn_ff) : '0;
      scan_q     = '0;
      scan_found = 1'b0;
      scan_idx   = '0;
      for (int k = 0; k < NQ; k++) begin
         scan_idx = (QW + 1)'(start_q) + (QW + 1)'(k);
         if (scan_idx >= (QW + 1)'(n_q)) scan_idx = scan_idx - (QW + 1)'(n_q);
         if (((QW + 1)'(k) < (QW + 1)'(n_q)) && !scan_found &&
             (fill_ff[scan_idx[IW-1:0]] != '0)) begin
            scan_found = 1'b1;
            scan_q     = scan_idx[IW-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- queue datapath
   assign fill_q  = fill_ff[q_ff];
   assign bytes_q = bytes_ff[q_ff];
   assign head_q  = head_ff[q_ff];
   assign pos_sum = (HW + 1)'(head_q) + (HW + 1)'(fill_q);
   assign pos     = (pos_sum >= (HW + 1)'(QUEUE_DEPTH)) ?
                    HW'(pos_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(pos_sum);
   assign byte_sum = (BW + 1)'(bytes_q) + (BW + 1)'(len_ff);

   always_comb begin
      drop = 1'b0;
      if (32'(fill_q) >= QUEUE_DEPTH) drop = 1'b1;
      if (queue_mode_ff && (32'(fill_q) >= 32'(pkt_limit))) drop = 1'b1;
      if (!queue_mode_ff && (byte_sum >= (BW + 1)'(byte_limit))) drop = 1'b1;
   end

   assign ram_wr_en   = enq_upd;
   assign ram_wr_addr = AW'(q_ff) * AW'(QUEUE_DEPTH) + AW'(pos);
   assign ram_wr_data = {len_ff, tag_ff};
   assign ram_rd_addr = AW'(q_ff) * AW'(QUEUE_DEPTH) + AW'(head_q);
   assign plen        = ram_rd_data[EW-1:TW];

   frrs_ram #(.WIDTH(EW), .DEPTH(RD)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- result and index
   always_comb begin
      q_in          = q_ff;
      turn_in       = turn_ff;
      res_status_in = res_status_ff;
      res_q_in      = res_q_ff;
      res_tag_in    = res_tag_ff;
      res_len_in    = res_len_ff;
      unique case (state_ff)
         frrs_pkg::FSM_LOOKUP: begin
            q_in       = (cmd_ff == frrs_pkg::CMD_DEQUEUE) ? scan_q : match_q;
            res_tag_in = '0;
            res_len_in = '0;
            if (cmd_ff == frrs_pkg::CMD_PROGRAM) begin
               res_status_in = frrs_pkg::ST_PROGRAMMED;
               res_q_in      = frrs_pkg::QIDX_WIDTH'(slot_ff);
            end else begin
               res_status_in = frrs_pkg::ST_ALL_EMPTY;
               res_q_in      = '0;
            end
         end
         frrs_pkg::FSM_ENQ: begin
            res_status_in = drop ? frrs_pkg::ST_DROPPED : frrs_pkg::ST_ENQUEUED;
            res_q_in      = frrs_pkg::QIDX_WIDTH'(q_ff);
         end
         frrs_pkg::FSM_DEQ_DONE: begin
            res_status_in = frrs_pkg::ST_DEQUEUED;
            res_q_in      = frrs_pkg::QIDX_WIDTH'(q_ff);
            res_tag_in    = frrs_pkg::TAGP_WIDTH'(ram_rd_data[TW-1:0]);
            res_len_in    = plen;
            turn_in       = ((QW'(q_ff) + 1'b1) == n_q) ? '0 : IW'(QW'(q_ff) + 1'b1);
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= frrs_pkg::FSM_IDLE;
         rsp_valid_ff  <= 1'b0;
         turn_ff       <= '0;
         flow_valid_ff <= '0;
         for (int i = 0; i < MAX_FLOWS; i++) begin
            flow_src_ff[i] <= '0;
            flow_dst_ff[i] <= '0;
         end
         for (int i = 0; i < NQ; i++) begin
            head_ff[i]  <= '0;
            fill_ff[i]  <= '0;
            bytes_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         turn_ff      <= turn_in;
         if ((state_ff == frrs_pkg::FSM_LOOKUP) && (cmd_ff == frrs_pkg::CMD_PROGRAM) &&
             (32'(slot_ff) < MAX_FLOWS)) begin
            flow_src_ff[IW'(slot_ff)]   <= src_ff;
            flow_dst_ff[IW'(slot_ff)]   <= dst_ff;
            flow_valid_ff[IW'(slot_ff)] <= 1'b1;
         end
         if (enq_upd) begin
            fill_ff[q_ff]  <= fill_q + 1'b1;
            bytes_ff[q_ff] <= BW'(byte_sum);
         end
         if (head_upd) begin
            head_ff[q_ff]  <= (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
            fill_ff[q_ff]  <= fill_q - 1'b1;
            bytes_ff[q_ff] <= bytes_q - BW'(plen);
         end
      end
      if (accept) begin
         cmd_ff  <= req_command;
         src_ff  <= req_src_address;
         dst_ff  <= req_dst_address;
         len_ff  <= req_packet_length;
         tag_ff  <= req_packet_tag[TW-1:0];
         slot_ff <= req_flow_slot;
      end
      q_ff          <= q_in;
      res_status_ff <= res_status_in;
      res_q_ff      <= res_q_in;
      res_tag_ff    <= res_tag_in;
      res_len_ff    <= res_len_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_q_ff      <= res_q_ff;
         rsp_tag_ff    <= res_tag_ff;
         rsp_len_ff    <= res_len_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_index = rsp_q_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_out_length  = rsp_len_ff;

endmodule
